// ===== rtl/aet_pkg.sv =====
// Shared types and constants of the arithmetic expression tokenizer.
// Holds the token kinds, the character codes and the queue entry format.
// No dependencies.
`default_nettype none

package aet_pkg;

  localparam int TokenValueW       = 63;
  localparam int ValueWidthDefault = 63;
  localparam int FifoDepthDefault  = 4;

  localparam logic [TokenValueW-1:0] MaxValueReset = {TokenValueW{1'b1}};

  typedef enum logic [3:0] {
    KindInt    = 4'd0,
    KindAdd    = 4'd1,
    KindSub    = 4'd2,
    KindMul    = 4'd3,
    KindDiv    = 4'd4,
    KindPow    = 4'd5,
    KindLparen = 4'd6,
    KindRparen = 4'd7,
    KindEnd    = 4'd8,
    KindError  = 4'd9
  } token_kind_e;

  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharMinus   = 8'h2D;
  localparam logic [7:0] CharStar    = 8'h2A;
  localparam logic [7:0] CharSlash   = 8'h2F;
  localparam logic [7:0] CharCaret   = 8'h5E;
  localparam logic [7:0] CharLparen  = 8'h28;
  localparam logic [7:0] CharRparen  = 8'h29;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharNul     = 8'h00;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;

  localparam logic [3:0] Radix = 4'd10;

  // Everything one text byte produces: an optional literal, an optional
  // operator or error token, and an optional end token, in that order.
  typedef struct packed {
    logic                   int_vld;
    logic [TokenValueW-1:0] int_val;
    logic                   mid_vld;
    token_kind_e            mid_kind;
    logic                   end_vld;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

`default_nettype wire

// ===== rtl/aet_front.sv =====
// Front end of the tokenizer: classifies each text byte, builds literals
// and writes one entry per productive byte into the queue.
// Depends on aet_pkg.
`default_nettype none

module aet_front
  import aet_pkg::*;
#(
  parameter int ValueWidth = ValueWidthDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire logic [7:0]             text_byte_i,
  input  wire logic                   end_of_text_i,
  input  wire logic [TokenValueW-1:0] max_value_i,
  output entry_t                      entry_o,
  output logic                        push_o
);

  localparam int ProdW = ValueWidth + 4;

  logic                  in_number_q, in_number_d;
  logic                  in_error_q, in_error_d;
  logic [ValueWidth-1:0] acc_q, acc_d;

  logic                  is_digit, is_skip, op_vld, fits;
  logic [3:0]            digit;
  token_kind_e           op_kind;
  logic [ProdW-1:0]      acc_ext, prod, limit_ext;
  entry_t                entry;

  always_comb begin
    is_digit  = (text_byte_i >= CharZero) && (text_byte_i <= CharNine);
    digit     = 4'(text_byte_i - CharZero);
    is_skip   = (text_byte_i == CharSpace) || (text_byte_i == CharNewline) ||
                (text_byte_i == CharNul);
    op_vld    = 1'b1;
    op_kind   = KindError;
    unique case (text_byte_i)
      CharPlus:   op_kind = KindAdd;
      CharMinus:  op_kind = KindSub;
      CharStar:   op_kind = KindMul;
      CharSlash:  op_kind = KindDiv;
      CharCaret:  op_kind = KindPow;
      CharLparen: op_kind = KindLparen;
      CharRparen: op_kind = KindRparen;
      default:    op_vld  = 1'b0;
    endcase

    // The literal fits when ten times the value plus the digit stays at or
    // below the limit; four extra bits keep the product exact.
    acc_ext   = {4'b0000, acc_q};
    prod      = (acc_ext << 3) + (acc_ext << 1) + {{ValueWidth{1'b0}}, digit};
    limit_ext = {4'b0000, max_value_i[ValueWidth-1:0]};
    fits      = (prod <= limit_ext);

    in_number_d = in_number_q;
    in_error_d  = in_error_q;
    acc_d       = acc_q;
    entry       = '0;
    entry.mid_kind = KindError;

    if (!in_error_q) begin
      if (is_digit) begin
        if (fits) begin
          acc_d       = prod[ValueWidth-1:0];
          in_number_d = 1'b1;
        end else begin
          // Overflow drops the partial literal.
          acc_d          = '0;
          in_number_d    = 1'b0;
          in_error_d     = 1'b1;
          entry.mid_vld  = 1'b1;
          entry.mid_kind = KindError;
        end
      end else begin
        entry.int_vld = in_number_q;
        entry.int_val = TokenValueW'(acc_q);
        acc_d         = '0;
        in_number_d   = 1'b0;
        if (is_skip) begin
          entry.mid_vld = 1'b0;
        end else if (op_vld) begin
          entry.mid_vld  = 1'b1;
          entry.mid_kind = op_kind;
        end else begin
          entry.mid_vld  = 1'b1;
          entry.mid_kind = KindError;
          in_error_d     = 1'b1;
        end
      end
    end

    if (end_of_text_i) begin
      if (in_number_d) begin
        entry.int_vld = 1'b1;
        entry.int_val = TokenValueW'(acc_d);
      end
      entry.end_vld = 1'b1;
      acc_d         = '0;
      in_number_d   = 1'b0;
      in_error_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_number_q <= 1'b0;
      in_error_q  <= 1'b0;
      acc_q       <= '0;
    end else if (accept_i) begin
      in_number_q <= in_number_d;
      in_error_q  <= in_error_d;
      acc_q       <= acc_d;
    end
  end

  assign entry_o = entry;
  assign push_o  = accept_i && (entry.int_vld || entry.mid_vld || entry.end_vld);

endmodule

`default_nettype wire

// ===== rtl/aet_fifo.sv =====
// Short register queue between the front end and the back end.
// Generic in width and depth; depends on aet_pkg only for defaults.
`default_nettype none

module aet_fifo
  import aet_pkg::*;
#(
  parameter int Width = EntryW,
  parameter int Depth = FifoDepthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/aet_back.sv =====
// Back end of the tokenizer: unpacks queue entries into single tokens and
// drives the output register.
// Depends on aet_pkg.
`default_nettype none

module aet_back
  import aet_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire entry_t                 entry_i,
  input  wire logic                   empty_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [3:0]                  token_kind_o,
  output logic [TokenValueW-1:0]      token_value_o,
  output logic                        last_token_o
);

  logic                   pend_int_q, pend_mid_q, pend_end_q;
  logic                   pend_int_d, pend_mid_d, pend_end_d;
  logic [TokenValueW-1:0] pend_val_q;
  token_kind_e            pend_kind_q;

  logic                   out_vld_q;
  token_kind_e            out_kind_q;
  logic [TokenValueW-1:0] out_val_q;
  logic                   out_last_q;

  logic                   take, have, load, pop;
  token_kind_e            nxt_kind;
  logic [TokenValueW-1:0] nxt_val;
  logic                   nxt_last;

  always_comb begin
    take       = !out_vld_q || out_ready_i;
    have       = pend_int_q || pend_mid_q || pend_end_q;
    load       = take && have;
    pend_int_d = pend_int_q;
    pend_mid_d = pend_mid_q;
    pend_end_d = pend_end_q;
    nxt_kind   = KindEnd;
    nxt_val    = '0;
    nxt_last   = 1'b0;
    priority if (pend_int_q) begin
      nxt_kind = KindInt;
      nxt_val  = pend_val_q;
      if (take) pend_int_d = 1'b0;
    end else if (pend_mid_q) begin
      nxt_kind = pend_kind_q;
      if (take) pend_mid_d = 1'b0;
    end else begin
      nxt_kind = KindEnd;
      nxt_last = 1'b1;
      if (take) pend_end_d = 1'b0;
    end
    // A new entry comes in once the last pending token has gone out.
    pop = !empty_i && !(pend_int_d || pend_mid_d || pend_end_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_int_q <= 1'b0;
      pend_mid_q <= 1'b0;
      pend_end_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (pop) begin
        pend_int_q <= entry_i.int_vld;
        pend_mid_q <= entry_i.mid_vld;
        pend_end_q <= entry_i.end_vld;
      end else begin
        pend_int_q <= pend_int_d;
        pend_mid_q <= pend_mid_d;
        pend_end_q <= pend_end_d;
      end
      if (take) begin
        out_vld_q <= have;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      pend_val_q  <= entry_i.int_val;
      pend_kind_q <= entry_i.mid_kind;
    end
    if (load) begin
      out_kind_q <= nxt_kind;
      out_val_q  <= nxt_val;
      out_last_q <= nxt_last;
    end
  end

  assign pop_o         = pop;
  assign out_valid_o   = out_vld_q;
  assign token_kind_o  = out_kind_q;
  assign token_value_o = out_val_q;
  assign last_token_o  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/arithmetic_expression_tokenizer_top.sv =====
// Top level of the arithmetic expression tokenizer: the max_value register,
// front end, entry queue and back end. Depends on aet_pkg, aet_front,
// aet_fifo and aet_back.
//
//   Channel  Dir  Handshake                Payload
//   in       in   in_valid_i/in_ready_o    text_byte_i, end_of_text_i
//   out      out  out_valid_o/out_ready_i  token_kind_o, token_value_o, last_token_o
//   cfg      in   cfg_valid_i/cfg_ready_o  max_value_i
//
// One text byte is taken per cycle while the entry queue has room; a byte
// yields its tokens in one entry, so the queue is written at most once a cycle.
// The back end sends one token per cycle while out_ready_i is high; a byte
// producing up to three tokens sends them in turn, and the output register
// sets that rate. A byte passes the entry queue, pending and output registers.
// Reset clears the token state, the queue and the output valid, and sets
// max_value to its largest value. The config port is always ready.
`default_nettype none

module arithmetic_expression_tokenizer_top
  import aet_pkg::*;
#(
  parameter int ValueWidth = ValueWidthDefault,
  parameter int FifoDepth  = FifoDepthDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [7:0]             text_byte_i,
  input  wire logic                   end_of_text_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [3:0]                  token_kind_o,
  output logic [TokenValueW-1:0]      token_value_o,
  output logic                        last_token_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [TokenValueW-1:0] max_value_i
);

  logic [TokenValueW-1:0] max_value_q;
  logic                   accept, push, pop, full, empty;
  entry_t                 wr_entry, rd_entry;
  logic [EntryW-1:0]      rd_bits;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= MaxValueReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_value_q <= max_value_i;
    end
  end

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  aet_front #(
    .ValueWidth(ValueWidth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .max_value_i  (max_value_q),
    .entry_o      (wr_entry),
    .push_o       (push)
  );

  aet_fifo #(
    .Width(EntryW),
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(wr_entry),
    .pop_i  (pop),
    .rdata_o(rd_bits),
    .full_o (full),
    .empty_o(empty)
  );

  assign rd_entry = entry_t'(rd_bits);

  aet_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (rd_entry),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .token_kind_o (token_kind_o),
    .token_value_o(token_value_o),
    .last_token_o (last_token_o)
  );

  // The front end only writes when the queue has room.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("entry written into a full queue");

  // The back end only takes an entry that is there.
  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("entry taken from an empty queue");

  // Only literal tokens carry a value, and only end tokens close an expression.
  a_token_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((token_kind_o == KindInt) || (token_value_o == '0)) &&
                    (last_token_o == (token_kind_o == KindEnd)))
    else $error("token fields do not match the token kind");

endmodule

`default_nettype wire
